FILE: rtl/core/clbs_pkg.sv
// ----------------------------------------------------------------------------
// clbs_pkg
// Types, codes and constant tables shared by the character-LCD bus sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

  // request kinds carried on the input stream
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_INIT  = 3'd1,
    OP_CMD   = 3'd2,
    OP_CHAR  = 3'd3,
    OP_GOTO  = 3'd4
  } op_e;

  // configuration register indexes
  localparam logic [1:0] CFG_FOUR_BIT_BUS = 2'd0;
  localparam logic [1:0] CFG_ROWS_IN_USE  = 2'd1;

  // sequencer phases, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_POWER   = 4'b0010,
    PH_EN_HIGH = 4'b0100,
    PH_EN_LOW  = 4'b1000
  } phase_e;

  localparam logic [7:0] CMD_SET_ADDRESS  = 8'h80;
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
  localparam logic [7:0] FS_EIGHT_BIT     = 8'h10;
  localparam logic [7:0] FS_TWO_LINES     = 8'h08;
  localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
  localparam logic [7:0] CMD_ENTRY_INC    = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] WAKE_NIBBLE      = 8'h30;
  localparam logic [7:0] FOUR_BIT_NIBBLE  = 8'h20;
  localparam logic [7:0] POWER_UP_MS      = 8'd230;

  localparam logic [4:0] INIT_LEN_FOUR  = 5'd9;
  localparam logic [4:0] INIT_LEN_EIGHT = 5'd7;

  // one step of the power-up sequence
  typedef struct packed {
    logic       is_byte;
    logic [7:0] value;
    logic [2:0] gap;
  } seq_elem_t;

  // result fields of one transaction
  typedef struct packed {
    logic       rejected;
    logic       ready_res;
    logic [7:0] bus_data;
    logic       enable;
    logic       reg_select;
  } result_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

  // init table lookup; steps outside the current table act as a plain byte
  function automatic seq_elem_t init_elem(input logic four_bit, input logic [4:0] step);
    seq_elem_t e;
    e = '{is_byte: 1'b1, value: 8'h00, gap: 3'd0};
    if (four_bit) begin
      case (step)
        5'd1:    e = '{1'b0, WAKE_NIBBLE, 3'd5};
        5'd2:    e = '{1'b0, WAKE_NIBBLE, 3'd1};
        5'd3:    e = '{1'b0, WAKE_NIBBLE, 3'd0};
        5'd4:    e = '{1'b0, FOUR_BIT_NIBBLE, 3'd0};
        5'd5:    e = '{1'b1, CMD_FUNCTION_SET | FS_TWO_LINES, 3'd0};
        5'd6:    e = '{1'b1, CMD_DISPLAY_OFF, 3'd0};
        5'd7:    e = '{1'b1, CMD_ENTRY_INC, 3'd0};
        5'd8:    e = '{1'b1, CMD_DISPLAY_ON, 3'd0};
        5'd9:    e = '{1'b1, CMD_CLEAR, 3'd0};
        default: e = '{1'b1, 8'h00, 3'd0};
      endcase
    end else begin
      case (step)
        5'd1:    e = '{1'b1, CMD_FUNCTION_SET | FS_EIGHT_BIT, 3'd5};
        5'd2:    e = '{1'b1, CMD_FUNCTION_SET | FS_EIGHT_BIT, 3'd1};
        5'd3:    e = '{1'b1, CMD_FUNCTION_SET | FS_EIGHT_BIT | FS_TWO_LINES, 3'd0};
        5'd4:    e = '{1'b1, CMD_DISPLAY_OFF, 3'd0};
        5'd5:    e = '{1'b1, CMD_ENTRY_INC, 3'd0};
        5'd6:    e = '{1'b1, CMD_DISPLAY_ON, 3'd0};
        5'd7:    e = '{1'b1, CMD_CLEAR, 3'd0};
        default: e = '{1'b1, 8'h00, 3'd0};
      endcase
    end
    return e;
  endfunction

endpackage

FILE: rtl/core/clbs_engine.sv
// ----------------------------------------------------------------------------
// clbs_engine
// Sequencer state, configuration registers and the per-transaction update.
// ----------------------------------------------------------------------------
module clbs_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [2:0]           cfg_data_i,
  input  logic                 item_en_i,
  input  logic [2:0]           operation_i,
  input  logic [7:0]           data_byte_i,
  input  logic [5:0]           column_i,
  input  logic [1:0]           row_i,
  output clbs_pkg::result_t    result_o
);
  import clbs_pkg::*;

  logic       four_bit_q, four_bit_d;
  logic [2:0] rows_q, rows_d;

  phase_e     phase_q, phase_d;
  logic [4:0] step_q, step_d;
  logic [7:0] ms_q, ms_d;
  logic [7:0] pending_q, pending_d;
  logic       low_q, low_d;
  logic       rs_q, rs_d;
  logic       en_q, en_d;
  logic [7:0] bus_q, bus_d;

  logic       rejected;
  logic       busy;
  logic [4:0] init_len;
  logic [4:0] step_inc;
  seq_elem_t  e_cur, e_first, e_next;
  logic       start_b;
  logic [7:0] start_val;
  logic       strobe;
  logic [7:0] strobe_pins;

  // config
  always_comb begin
    four_bit_d = four_bit_q;
    rows_d     = rows_q;
    if (cfg_we_i && cfg_index_i == CFG_FOUR_BIT_BUS) begin
      four_bit_d = cfg_data_i[0];
    end
    if (cfg_we_i && cfg_index_i == CFG_ROWS_IN_USE) begin
      rows_d = cfg_data_i;
    end
  end

  assign busy     = (phase_q != PH_IDLE);
  assign init_len = four_bit_q ? INIT_LEN_FOUR : INIT_LEN_EIGHT;
  assign step_inc = step_q + 5'd1;
  assign e_cur    = init_elem(four_bit_q, step_q);
  assign e_first  = init_elem(four_bit_q, 5'd1);
  assign e_next   = init_elem(four_bit_q, step_inc);

  always_comb begin
    phase_d     = phase_q;
    step_d      = step_q;
    ms_d        = ms_q;
    pending_d   = pending_q;
    low_d       = low_q;
    rs_d        = rs_q;
    en_d        = en_q;
    bus_d       = bus_q;
    rejected    = 1'b0;
    start_b     = 1'b0;
    start_val   = 8'h00;
    strobe      = 1'b0;
    strobe_pins = 8'h00;

    if (item_en_i) begin
      if (op_e'(operation_i) == OP_TICK) begin
        if (busy) begin
          if (ms_q > 8'd1) begin
            ms_d = ms_q - 8'd1;
          end else begin
            ms_d = 8'd0;
            unique case (phase_q)
              PH_POWER: begin
                step_d = 5'd1;
                rs_d   = 1'b0;
                if (e_first.is_byte) begin
                  start_b   = 1'b1;
                  start_val = e_first.value;
                end else begin
                  low_d       = 1'b0;
                  strobe      = 1'b1;
                  strobe_pins = {e_first.value[7:4], 4'h0};
                end
              end
              PH_EN_HIGH: begin
                en_d    = 1'b0;
                ms_d    = (four_bit_q && e_cur.is_byte) ? 8'd2 : 8'd1 + 8'(e_cur.gap);
                phase_d = PH_EN_LOW;
              end
              PH_EN_LOW: begin
                if (low_q) begin
                  low_d       = 1'b0;
                  strobe      = 1'b1;
                  strobe_pins = {pending_q[3:0], 4'h0};
                end else if (step_q != 5'd0) begin
                  if (step_inc == 5'd0 || step_inc > init_len) begin
                    step_d  = 5'd0;
                    phase_d = PH_IDLE;
                  end else begin
                    step_d = step_inc;
                    rs_d   = 1'b0;
                    if (e_next.is_byte) begin
                      start_b   = 1'b1;
                      start_val = e_next.value;
                    end else begin
                      low_d       = 1'b0;
                      strobe      = 1'b1;
                      strobe_pins = {e_next.value[7:4], 4'h0};
                    end
                  end
                end else begin
                  phase_d = PH_IDLE;
                end
              end
              default: phase_d = PH_IDLE;
            endcase
          end
        end
      end else if (busy) begin
        rejected = 1'b1;
      end else begin
        case (op_e'(operation_i))
          OP_INIT: begin
            rs_d    = 1'b0;
            en_d    = 1'b0;
            step_d  = 5'd0;
            low_d   = 1'b0;
            ms_d    = POWER_UP_MS;
            phase_d = PH_POWER;
          end
          OP_CMD, OP_CHAR: begin
            step_d    = 5'd0;
            rs_d      = (op_e'(operation_i) == OP_CHAR);
            start_b   = 1'b1;
            start_val = data_byte_i;
          end
          OP_GOTO: begin
            if (row_i == 2'd0 || {1'b0, row_i} < rows_q) begin
              step_d    = 5'd0;
              rs_d      = 1'b0;
              start_b   = 1'b1;
              start_val = CMD_SET_ADDRESS + row_base(row_i) + {2'b00, column_i};
            end
          end
          default: rejected = 1'b1;
        endcase
      end
    end

    // byte start: high nibble first in 4-bit mode
    if (start_b) begin
      pending_d = start_val;
      strobe    = 1'b1;
      if (four_bit_q) begin
        low_d       = 1'b1;
        strobe_pins = {start_val[7:4], 4'h0};
      end else begin
        low_d       = 1'b0;
        strobe_pins = start_val;
      end
    end

    // raise EN for one tick
    if (strobe) begin
      bus_d   = strobe_pins;
      en_d    = 1'b1;
      ms_d    = 8'd1;
      phase_d = PH_EN_HIGH;
    end
  end

  assign result_o = '{
    rejected:   rejected,
    ready_res:  (phase_d == PH_IDLE),
    bus_data:   bus_d,
    enable:     en_d,
    reg_select: rs_d
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_bit_q <= 1'b1;
      rows_q     <= 3'd4;
      phase_q    <= PH_IDLE;
      step_q     <= 5'd0;
      ms_q       <= 8'd0;
      pending_q  <= 8'd0;
      low_q      <= 1'b0;
      rs_q       <= 1'b0;
      en_q       <= 1'b0;
      bus_q      <= 8'd0;
    end else begin
      four_bit_q <= four_bit_d;
      rows_q     <= rows_d;
      phase_q    <= phase_d;
      step_q     <= step_d;
      ms_q       <= ms_d;
      pending_q  <= pending_d;
      low_q      <= low_d;
      rs_q       <= rs_d;
      en_q       <= en_d;
      bus_q      <= bus_d;
    end
  end

endmodule

FILE: rtl/core/char_lcd_bus_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_bus_sequencer
// Character-LCD parallel bus sequencer with stream request and result ports.
// ----------------------------------------------------------------------------
// Each input transaction is a millisecond tick, an init request, a command
// byte, a character byte or a cursor goto, and produces exactly one result
// transaction carrying the RS, EN and data pin levels after that request plus
// ready and rejected flags. The block takes one transaction per clock cycle
// when the result side keeps up; a request is held in the input register
// and its result is loaded into the output register once that register is
// free, and result valid rises with that load. The combinational sequencer
// update between those two registers sets this rate.
// Configuration writes (index 0 four_bit_bus, index 1 rows_in_use) are always
// ready and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_bus_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // data_byte[7:0], column[13:8], row[15:14]
  input  logic [2:0]  s_axis_tuser_i,   // operation[2:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // reg_select[0], enable[1], bus_data[9:2],
                                        // ready_res[10], rejected[11], zero[15:12]
);
  import clbs_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  logic [2:0] op_q;
  logic [7:0] data_q;
  logic [5:0] col_q;
  logic [1:0] row_q;

  // output register
  logic       out_valid_q, out_valid_d;
  result_t    out_q;

  result_t    step_res;
  logic       in_take;
  logic       load_out;

  // configuration never stalls
  assign cfg_ready_o = 1'b1;

  // the engine consumes the held request when the output register is free
  assign load_out        = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || load_out;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (load_out) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  clbs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_en_i   (load_out),
    .operation_i (op_q),
    .data_byte_i (data_q),
    .column_i    (col_q),
    .row_i       (row_q),
    .result_o    (step_res)
  );

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= s_axis_tuser_i;
      data_q <= s_axis_tdata_i[7:0];
      col_q  <= s_axis_tdata_i[13:8];
      row_q  <= s_axis_tdata_i[15:14];
    end
    if (load_out) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_q};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character-LCD bus sequencer.
// ----------------------------------------------------------------------------
// A queue of requests is filled phase by phase from an initial block and fed
// to the request stream by a clocked driver. A local pin-level model is
// updated on every accepted request transaction, and the result it gives is
// queued. A clocked monitor compares every accepted result transaction, field
// by field, with the oldest queued result. Each phase runs under its own
// bus width and row count; the register writes only happen once the
// sequencer has reported ready and nothing is in flight. Stimulus is mostly
// well-formed request/tick runs, with noise, short runs that provoke busy
// rejections, and a few power-up sequences in both bus widths.
// ----------------------------------------------------------------------------
module tb_top;
  import clbs_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 150;
  localparam int BOOT_TICKS   = 280;  // enough for the power-up sequence in either width

  // cursor row base addresses
  localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  // register settings per phase, extremes of both fields included
  localparam logic [2:0] PHASE_FOUR_BIT [PHASES] = '{3'd1, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0};
  localparam logic [2:0] PHASE_ROWS     [PHASES] = '{3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7};

  typedef struct {
    logic [2:0] op;
    logic [7:0] data;
    logic [5:0] col;
    logic [1:0] row;
  } lcd_req_t;

  // clock, reset and dut ports
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index   = '0;
  logic [2:0]  cfg_data    = '0;
  logic        req_valid   = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] req_tdata   = '0;
  logic [2:0]  req_tuser   = '0;
  logic        m_axis_tvalid_o;
  logic        res_ready   = 1'b0;
  logic [15:0] m_axis_tdata_o;

  // pending requests and expected pin levels
  lcd_req_t req_q[$];
  result_t  pin_levels_q[$];

  // idling percentages for the current phase
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // pin-level model state and its copy of the registers
  logic       mdl_four_bit = 1'b1;
  logic [2:0] mdl_rows     = 3'd4;
  phase_e     seq_phase    = PH_IDLE;
  logic [4:0] boot_step    = '0;
  logic [7:0] ms_left      = '0;
  logic [7:0] pend_byte    = '0;
  logic       low_pend     = 1'b0;
  logic       rs_lvl       = 1'b0;
  logic       en_lvl       = 1'b0;
  logic [7:0] bus_lvl      = '0;

  // bookkeeping
  int  n_errors  = 0;
  int  n_results = 0;
  int  n_ticks   = 0;
  int  n_boots   = 0;
  int  n_bytes   = 0;
  int  n_rejects = 0;
  int  queued    = 0;
  logic last_ready = 1'b1;
  lcd_req_t held_req;

  char_lcd_bus_sequencer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (req_tdata),   // data_byte[7:0], column[13:8], row[15:14]
    .s_axis_tuser_i  (req_tuser),   // operation[2:0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // pin-level model
  // --------------------------------------------------------------------------

  // one step of the power-up list; steps outside the list of the current
  // width behave as a plain byte with no extra gap
  function automatic void boot_entry(input logic four, input logic [4:0] step,
                                     output logic is_byte, output logic [7:0] value,
                                     output logic [2:0] gap);
    logic [4:0] len;
    len     = four ? INIT_LEN_FOUR : INIT_LEN_EIGHT;
    is_byte = 1'b1;
    value   = 8'h00;
    gap     = 3'd0;
    if (step != 0 && step <= len) begin
      // extra settle time after the first two wake-up transfers
      if (step == 5'd1) gap = 3'd5;
      if (step == 5'd2) gap = 3'd1;
      if (four) begin
        // three wake-up nibbles and the four-bit nibble, then the command bytes
        is_byte = (step > 5'd4);
        if (step <= 5'd3)      value = WAKE_NIBBLE;
        else if (step == 5'd4) value = FOUR_BIT_NIBBLE;
        else if (step == 5'd5) value = CMD_FUNCTION_SET | FS_TWO_LINES;
        else if (step == 5'd6) value = CMD_DISPLAY_OFF;
        else if (step == 5'd7) value = CMD_ENTRY_INC;
        else if (step == 5'd8) value = CMD_DISPLAY_ON;
        else                   value = CMD_CLEAR;
      end else begin
        if (step <= 5'd2)      value = CMD_FUNCTION_SET | FS_EIGHT_BIT;
        else if (step == 5'd3) value = CMD_FUNCTION_SET | FS_EIGHT_BIT | FS_TWO_LINES;
        else if (step == 5'd4) value = CMD_DISPLAY_OFF;
        else if (step == 5'd5) value = CMD_ENTRY_INC;
        else if (step == 5'd6) value = CMD_DISPLAY_ON;
        else                   value = CMD_CLEAR;
      end
    end
  endfunction

  task automatic raise_strobe(input logic [7:0] pins);
    bus_lvl   = pins;
    en_lvl    = 1'b1;
    ms_left   = 8'd1;
    seq_phase = PH_EN_HIGH;
  endtask

  // a byte is one strobe on 8 bits, or high nibble first on D7..D4
  task automatic send_byte(input logic [7:0] b);
    pend_byte = b;
    low_pend  = mdl_four_bit;
    raise_strobe(mdl_four_bit ? {b[7:4], 4'h0} : b);
  endtask

  task automatic start_boot_step();
    logic       is_byte;
    logic [7:0] value;
    logic [2:0] gap;
    boot_entry(mdl_four_bit, boot_step, is_byte, value, gap);
    rs_lvl = 1'b0;
    if (is_byte) begin
      send_byte(value);
    end else begin
      low_pend = 1'b0;
      raise_strobe({value[7:4], 4'h0});
    end
  endtask

  // the current timed phase has run out
  task automatic timer_expired();
    logic       is_byte;
    logic [7:0] value;
    logic [2:0] gap;
    case (seq_phase)
      PH_POWER: begin
        boot_step = 5'd1;
        start_boot_step();
      end
      PH_EN_HIGH: begin
        boot_entry(mdl_four_bit, boot_step, is_byte, value, gap);
        en_lvl    = 1'b0;
        // nibbles of a byte get an extra millisecond low
        ms_left   = (mdl_four_bit && is_byte) ? 8'd2 : 8'd1 + gap;
        seq_phase = PH_EN_LOW;
      end
      PH_EN_LOW: begin
        if (low_pend) begin
          low_pend = 1'b0;
          raise_strobe({pend_byte[3:0], 4'h0});
        end else if (boot_step != 0) begin
          boot_step = boot_step + 5'd1;
          if (boot_step == 0 ||
              boot_step > (mdl_four_bit ? INIT_LEN_FOUR : INIT_LEN_EIGHT)) begin
            boot_step = '0;
            seq_phase = PH_IDLE;
          end else begin
            start_boot_step();
          end
        end else begin
          seq_phase = PH_IDLE;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
  endtask

  // update the model with one request, return the pin levels after it
  task automatic apply_request(input lcd_req_t req, output result_t res);
    logic       busy;
    logic       rej;
    logic [7:0] addr;
    busy = (seq_phase != PH_IDLE);
    rej  = 1'b0;
    if (req.op == OP_TICK) begin
      n_ticks++;
      // a tick while idle changes nothing
      if (busy) begin
        if (ms_left > 8'd1) begin
          ms_left = ms_left - 8'd1;
        end else begin
          ms_left = '0;
          timer_expired();
        end
      end
    end else if (req.op > OP_GOTO || busy) begin
      // undefined codes and requests while busy are dropped
      rej = 1'b1;
    end else if (req.op == OP_INIT) begin
      n_boots++;
      rs_lvl    = 1'b0;
      en_lvl    = 1'b0;
      boot_step = '0;
      low_pend  = 1'b0;
      ms_left   = POWER_UP_MS;
      seq_phase = PH_POWER;
    end else if (req.op == OP_CMD || req.op == OP_CHAR) begin
      n_bytes++;
      boot_step = '0;
      rs_lvl    = (req.op == OP_CHAR);
      send_byte(req.data);
    end else if (req.row == 0 || req.row < mdl_rows) begin
      // goto; a row outside the rows in use sends nothing, row 0 always goes
      n_bytes++;
      boot_step = '0;
      rs_lvl    = 1'b0;
      addr      = CMD_SET_ADDRESS + ROW_BASE[req.row] + {2'b00, req.col};  // wraps
      send_byte(addr);
    end
    if (rej) n_rejects++;
    res.reg_select = rs_lvl;
    res.enable     = en_lvl;
    res.bus_data   = bus_lvl;
    res.ready_res  = (seq_phase == PH_IDLE);
    res.rejected   = rej;
  endtask

  // --------------------------------------------------------------------------
  // request driver: predicts on every accepted transaction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && s_axis_tready_o) begin
        apply_request(held_req, want);
        pin_levels_q.push_back(want);
      end
      if (!req_valid || s_axis_tready_o) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          held_req = req_q.pop_front();
          req_valid <= 1'b1;
          req_tdata <= {held_req.row, held_req.col, held_req.data};
          req_tuser <= held_req.op;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    res_ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // result monitor
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && res_ready) begin
      got = result_t'(m_axis_tdata_o[11:0]);
      n_results++;
      if (pin_levels_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", n_results));
      end else begin
        want = pin_levels_q.pop_front();
        if (got.reg_select !== want.reg_select)
          report_mismatch($sformatf("result %0d reg_select %b, model %b",
                                    n_results, got.reg_select, want.reg_select));
        if (got.enable !== want.enable)
          report_mismatch($sformatf("result %0d enable %b, model %b",
                                    n_results, got.enable, want.enable));
        if (got.bus_data !== want.bus_data)
          report_mismatch($sformatf("result %0d bus_data %h, model %h",
                                    n_results, got.bus_data, want.bus_data));
        if (got.ready_res !== want.ready_res)
          report_mismatch($sformatf("result %0d ready_res %b, model %b",
                                    n_results, got.ready_res, want.ready_res));
        if (got.rejected !== want.rejected)
          report_mismatch($sformatf("result %0d rejected %b, model %b",
                                    n_results, got.rejected, want.rejected));
      end
      last_ready = got.ready_res;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic push_req(input logic [2:0] op, input logic [7:0] data,
                          input logic [5:0] col, input logic [1:0] row);
    lcd_req_t r;
    r.op   = op;
    r.data = data;
    r.col  = col;
    r.row  = row;
    req_q.push_back(r);
    queued++;
  endtask

  task automatic push_ticks(input int count);
    for (int k = 0; k < count; k++)
      push_req(OP_TICK, 8'($urandom), 6'($urandom), 2'($urandom));
  endtask

  // register write on its own channel
  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CFG_FOUR_BIT_BUS) mdl_four_bit = val[0];
    else if (idx == CFG_ROWS_IN_USE) mdl_rows = val;
  endtask

  // every request accepted and every result checked
  task automatic drain();
    while (req_q.size() != 0 || req_valid || pin_levels_q.size() != 0)
      @(posedge clk_i);
  endtask

  // tick the sequencer until it reports ready, so registers can be written
  task automatic settle_idle();
    drain();
    while (!last_ready) begin
      push_ticks(1);
      drain();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // extremes and special cases, reset register settings
  task automatic queue_directed();
    push_ticks(1);                                   // tick while idle
    for (int k = int'(OP_GOTO) + 1; k <= 7; k++)     // undefined operation codes
      push_req(3'(k), 8'hFF, 6'h3F, 2'd3);
    push_req(OP_CMD, 8'h00, 6'h00, 2'd0);
    push_ticks(6);
    push_req(OP_CHAR, 8'hFF, 6'h3F, 2'd3);
    push_req(OP_CMD, 8'hAA, 6'h15, 2'd1);            // busy, dropped
    push_ticks(6);
    push_req(OP_GOTO, 8'h00, 6'h3F, 2'd3);           // address wraps past 0xff
    push_ticks(6);
  endtask

  task automatic queue_boot();
    push_req(OP_INIT, 8'($urandom), 6'($urandom), 2'($urandom));
    push_ticks(BOOT_TICKS + $urandom_range(0, 6));
  endtask

  // one random run: mostly a request followed by enough ticks to finish it
  task automatic queue_random_run();
    int unsigned roll;
    int          need;
    int          ticks;
    roll = $urandom_range(99);
    need = mdl_four_bit ? 6 : 2;
    if (roll < 12) begin
      // noise: any code, any fields
      push_req(3'($urandom), 8'($urandom), 6'($urandom), 2'($urandom));
    end else if (roll < 13) begin
      queue_boot();
    end else begin
      push_req(3'($urandom_range(int'(OP_CMD), int'(OP_GOTO))),
               8'($urandom), 6'($urandom), 2'($urandom));
      // cut short now and then so the next request lands while busy
      ticks = ($urandom_range(99) < 15) ? $urandom_range(0, need - 1)
                                        : need + $urandom_range(0, 2);
      if ($urandom_range(99) < 15 && ticks > 1) begin
        push_ticks(1);
        push_req(3'($urandom_range(int'(OP_INIT), int'(OP_GOTO))),
                 8'($urandom), 6'($urandom), 2'($urandom));
        ticks--;
      end
      push_ticks(ticks);
    end
  endtask

  initial begin
    int start;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      // receiver-heavy stalls, then sender-heavy gaps, then full rate
      case (ph % 3)
        0: begin send_gap_pct = 33; recv_stall_pct = 75; end
        1: begin send_gap_pct = 75; recv_stall_pct = 33; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(CFG_FOUR_BIT_BUS, PHASE_FOUR_BIT[ph]);
      write_reg(CFG_ROWS_IN_USE, PHASE_ROWS[ph]);
      if (ph == 0) queue_directed();
      // power-up sequence in both bus widths
      if (ph < 2) queue_boot();
      start = queued;
      while (queued - start < PHASE_ITEMS) queue_random_run();
      settle_idle();
    end
    repeat (20) @(posedge clk_i);
    $display("covered %0d transactions: %0d ticks, %0d power-up runs, %0d bytes, %0d dropped",
             n_results, n_ticks, n_boots, n_bytes, n_rejects);
    $display("%0d bus/row settings, %0d mismatches", PHASES, n_errors);
    if (n_errors == 0 && pin_levels_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("timeout with %0d results still pending", pin_levels_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/clbs_pkg.sv
rtl/core/clbs_engine.sv
rtl/core/char_lcd_bus_sequencer.sv
test/tb_top.sv
